[rtl/cpq_pkg.sv]
// ----------------------------------------------------------------------------
// cpq_pkg
// Shared types and register indexes for the coin pulse qualifier counter.
// ----------------------------------------------------------------------------
package cpq_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned PPC_W      = 8;
  localparam int unsigned COUNT_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_COIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 3'd4;

  localparam logic [WIDTH_W-1:0] MIN_PULSE_RST = 16'd20;
  localparam logic [WIDTH_W-1:0] MAX_PULSE_RST = 16'd200;
  localparam logic [WIDTH_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [PPC_W-1:0]   PPC_RST       = 8'd1;
  localparam logic               INIT_LEVEL_RST = 1'b0;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_pulse;
    logic [WIDTH_W-1:0] max_pulse;
    logic [WIDTH_W-1:0] debounce;
    logic [PPC_W-1:0]   pulses_per_coin;
    logic               initial_level;
  } cfg_t;

  typedef struct packed {
    logic               pulse_accepted;
    logic               coin_added;
    logic [COUNT_W-1:0] total_pulses;
    logic [COUNT_W-1:0] total_coins;
    logic               learned_idle;
  } result_t;

endpackage

[rtl/cpq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cpq_cfg_regs
// Configuration register file; flags a write of the initial level so the
// line state can be reloaded.
// ----------------------------------------------------------------------------
module cpq_cfg_regs
  import cpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg,
  output logic                  level_load
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse       <= MIN_PULSE_RST;
      cfg.max_pulse       <= MAX_PULSE_RST;
      cfg.debounce        <= DEBOUNCE_RST;
      cfg.pulses_per_coin <= PPC_RST;
      cfg.initial_level   <= INIT_LEVEL_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_PULSE:       cfg.min_pulse       <= wr_data;
        REG_MAX_PULSE:       cfg.max_pulse       <= wr_data;
        REG_DEBOUNCE:        cfg.debounce        <= wr_data;
        REG_PULSES_PER_COIN: cfg.pulses_per_coin <= wr_data[PPC_W-1:0];
        REG_INITIAL_LEVEL:   cfg.initial_level   <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign level_load = wr_en && (wr_index == REG_INITIAL_LEVEL);

endmodule

[rtl/cpq_core.sv]
// ----------------------------------------------------------------------------
// cpq_core
// Line state, pulse qualification, debounce and pulse/coin counters. Computes
// the result for the sample at its input and commits the state on step.
// ----------------------------------------------------------------------------
module cpq_core
  import cpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              level_load,
  input  logic              load_level,
  input  logic              step,
  input  logic              line_level,
  input  logic [TIME_W-1:0] time_ms,
  output result_t           res
);

  logic               current_level;
  logic [TIME_W-1:0]  level_start_time;
  logic               idle_level;
  logic               has_accepted;
  logic [TIME_W-1:0]  last_accept_time;
  logic [COUNT_W-1:0] pulse_total;
  logic [PPC_W-1:0]   pulse_residue;
  logic [COUNT_W-1:0] coin_total;

  logic               idle_level_next;
  logic [COUNT_W-1:0] pulse_total_next;
  logic [PPC_W-1:0]   pulse_residue_next;
  logic [COUNT_W-1:0] coin_total_next;

  logic               changed;
  logic [TIME_W-1:0]  duration;
  logic [TIME_W-1:0]  spacing;
  logic               too_long;
  logic               is_pulse;
  logic               bounced;
  logic               accept;
  logic [PPC_W-1:0]   need;
  logic [PPC_W-1:0]   residue_inc;
  logic               coin;

  always_comb begin
    changed     = line_level != current_level;
    duration    = time_ms - level_start_time;
    spacing     = time_ms - last_accept_time;
    too_long    = duration > TIME_W'(cfg.max_pulse);
    is_pulse    = (current_level != idle_level) && (duration >= TIME_W'(cfg.min_pulse));
    bounced     = has_accepted && (spacing < TIME_W'(cfg.debounce));
    accept      = changed && !too_long && is_pulse && !bounced;
    // zero pulses per coin acts as one
    need        = (cfg.pulses_per_coin == '0) ? PPC_W'(1) : cfg.pulses_per_coin;
    residue_inc = pulse_residue + PPC_W'(1);
    coin        = accept && (residue_inc >= need);

    idle_level_next    = (changed && too_long) ? current_level : idle_level;
    pulse_total_next   = accept ? pulse_total + COUNT_W'(1) : pulse_total;
    coin_total_next    = coin ? coin_total + COUNT_W'(1) : coin_total;
    pulse_residue_next = coin ? '0 : (accept ? residue_inc : pulse_residue);

    res.pulse_accepted = accept;
    res.coin_added     = coin;
    res.total_pulses   = pulse_total_next;
    res.total_coins    = coin_total_next;
    res.learned_idle   = idle_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level    <= INIT_LEVEL_RST;
      idle_level       <= INIT_LEVEL_RST;
      level_start_time <= '0;
      has_accepted     <= 1'b0;
      last_accept_time <= '0;
      pulse_total      <= '0;
      pulse_residue    <= '0;
      coin_total       <= '0;
    end else if (level_load) begin
      current_level <= load_level;
      idle_level    <= load_level;
    end else if (step) begin
      idle_level    <= idle_level_next;
      pulse_total   <= pulse_total_next;
      pulse_residue <= pulse_residue_next;
      coin_total    <= coin_total_next;
      if (changed) begin
        current_level    <= line_level;
        level_start_time <= time_ms;
      end
      if (accept) begin
        has_accepted     <= 1'b1;
        last_accept_time <= time_ms;
      end
    end
  end

endmodule

[rtl/coin_pulse_qualifier_counter_unit.sv]
// ----------------------------------------------------------------------------
// coin_pulse_qualifier_counter_unit
// Coin line pulse qualifier with learned idle polarity, debounce and
// pulse/coin counters.
// ----------------------------------------------------------------------------
// Takes one line sample per clock while results are taken. A request is
// captured in an input register, evaluated against the line state and its
// result lands in the output register, so a new sample is accepted every
// cycle while results are taken. The single-cycle rate is set by the state
// update loop (level, timestamps, counters). A stalled output holds one
// result plus one queued sample before in_ready drops. Configuration writes
// are always ready and should be issued only while no request is in flight;
// writing initial_level also reloads the current and learned idle level.
module coin_pulse_qualifier_counter_unit
  import cpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  line_level,
  input  logic [TIME_W-1:0]     time_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pulse_accepted,
  output logic                  coin_added,
  output logic [COUNT_W-1:0]    total_pulses,
  output logic [COUNT_W-1:0]    total_coins,
  output logic                  learned_idle
);

  cfg_t              cfg;
  logic              level_load;
  logic              s1_valid;
  logic              s1_level;
  logic [TIME_W-1:0] s1_time;
  logic              advance;
  logic              step;
  result_t           res;

  assign cfg_ready = 1'b1;

  cpq_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .cfg        (cfg),
    .level_load (level_load)
  );

  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level <= line_level;
      s1_time  <= time_ms;
    end
  end

  cpq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .level_load (level_load),
    .load_level (cfg_data[0]),
    .step       (step),
    .line_level (s1_level),
    .time_ms    (s1_time),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pulse_accepted <= res.pulse_accepted;
      coin_added     <= res.coin_added;
      total_pulses   <= res.total_pulses;
      total_coins    <= res.total_coins;
      learned_idle   <= res.learned_idle;
    end
  end

  // a coin only completes on an accepted pulse
  a_coin_needs_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!coin_added || pulse_accepted))
    else $error("coin_added without pulse_accepted");

  // back pressure only when both stages hold a request
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled with free stage");

  // a queued request is never dropped while the output stalls
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_time) && $stable(s1_level)))
    else $error("queued request lost during stall");

  // the result register is never loaded while the output stalls
  a_pulse_step: assert property (@(posedge clk) disable iff (rst)
    (step && out_valid && !out_ready) |-> 1'b0)
    else $error("result register overwritten while stalled");

endmodule
